[rtl/core/bmbs_pkg.sv]
// Shared constants and types of the Boyer-Moore byte search block.
package bmbs_pkg;

  localparam int unsigned PAT_MAX = 32;
  localparam int unsigned PAT_AW  = $clog2(PAT_MAX);
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned ALPHA   = 256;
  localparam logic [7:0]  NEWLINE = 8'h0A;
  localparam logic [31:0] U32_TOP = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_PAT  = 2'd0,
    OP_TEXT = 2'd1,
    OP_EOT  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    A_NONE,
    A_PAT_WR,
    A_EOT,
    A_INIT,
    A_BC_RD,
    A_BC_WR,
    A_GS1_INIT,
    A_GS1_RD,
    A_GS1_WRT,
    A_GS1_WRF,
    A_K_INC,
    A_GS2_INIT,
    A_GS2_RD,
    A_GS2_WR,
    A_DONE,
    A_STORE,
    A_CMP_RD,
    A_J_DEC,
    A_SHIFT_RD,
    A_SHIFT_WR,
    A_EMIT
  } act_e;

  typedef struct packed {
    act_e act;
    logic latch;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic pos_max;
    logic tables_ready;
    logic n_zero;
    logic n_one;
    logic i_last;
    logic i_zero;
    logic i_last2;
    logic k_done;
    logic k_lt_i;
    logic eq;
    logic weq;
    logic j_zero;
    logic cmp_now;
    logic out_full;
  } status_t;

endpackage

[rtl/core/bmbs_if.sv]
// Valid/ready channel interfaces for input items and match results.
interface bmbs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [4:0] pattern_index;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output pattern_index,
                  output data_byte, input ready);
  modport sink   (input valid, input operation, input pattern_index,
                  input data_byte, output ready);
endinterface

interface bmbs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_offset;
  logic [31:0] line_no;

  modport source (output valid, output match_offset, output line_no,
                  input ready);
  modport sink   (input valid, input match_offset, input line_no,
                  output ready);
endinterface

[rtl/core/bmbs_ctrl.sv]
// Sequencer for table build, text store, backward compare and shift.
module bmbs_ctrl import bmbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_DECODE   = 16'h0002,
    S_BC_RD    = 16'h0004,
    S_BC_WR    = 16'h0008,
    S_GS1_INIT = 16'h0010,
    S_GS1_TEST = 16'h0020,
    S_GS1_CMP  = 16'h0040,
    S_GS2_INIT = 16'h0080,
    S_GS2_RD   = 16'h0100,
    S_GS2_CMP  = 16'h0200,
    S_DONE     = 16'h0400,
    S_STORE    = 16'h0800,
    S_CMP_RD   = 16'h1000,
    S_CMP_CHK  = 16'h2000,
    S_SHIFT_WR = 16'h4000,
    S_MATCH    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o.act   = A_NONE;
    cmd_o.latch = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.op)
          OP_PAT: begin
            cmd_o.act = A_PAT_WR;
            state_d   = S_IDLE;
          end
          OP_EOT: begin
            cmd_o.act = A_EOT;
            state_d   = S_IDLE;
          end
          OP_TEXT: begin
            priority if (status_i.pos_max) begin
              state_d = S_IDLE;
            end else if (!status_i.tables_ready) begin
              cmd_o.act = A_INIT;
              state_d   = status_i.n_zero ? S_DONE : S_BC_RD;
            end else begin
              state_d = S_STORE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_BC_RD: begin
        cmd_o.act = A_BC_RD;
        state_d   = S_BC_WR;
      end
      S_BC_WR: begin
        cmd_o.act = A_BC_WR;
        state_d   = status_i.i_last ? S_GS1_INIT : S_BC_RD;
      end
      S_GS1_INIT: begin
        cmd_o.act = A_GS1_INIT;
        state_d   = S_GS1_TEST;
      end
      S_GS1_TEST: begin
        if (status_i.k_done) begin
          cmd_o.act = A_GS1_WRT;
          state_d   = status_i.i_zero ? S_GS2_INIT : S_GS1_TEST;
        end else begin
          cmd_o.act = A_GS1_RD;
          state_d   = S_GS1_CMP;
        end
      end
      S_GS1_CMP: begin
        if (status_i.eq) begin
          cmd_o.act = A_K_INC;
          state_d   = S_GS1_TEST;
        end else begin
          cmd_o.act = A_GS1_WRF;
          state_d   = status_i.i_zero ? S_GS2_INIT : S_GS1_TEST;
        end
      end
      S_GS2_INIT: begin
        if (status_i.n_one) begin
          state_d = S_DONE;
        end else begin
          cmd_o.act = A_GS2_INIT;
          state_d   = S_GS2_RD;
        end
      end
      S_GS2_RD: begin
        cmd_o.act = A_GS2_RD;
        state_d   = S_GS2_CMP;
      end
      S_GS2_CMP: begin
        if (status_i.eq && status_i.k_lt_i) begin
          cmd_o.act = A_K_INC;
          state_d   = S_GS2_RD;
        end else begin
          cmd_o.act = A_GS2_WR;
          state_d   = status_i.i_last2 ? S_DONE : S_GS2_RD;
        end
      end
      S_DONE: begin
        cmd_o.act = A_DONE;
        state_d   = S_STORE;
      end
      S_STORE: begin
        cmd_o.act = A_STORE;
        state_d   = status_i.cmp_now ? S_CMP_RD : S_IDLE;
      end
      S_CMP_RD: begin
        cmd_o.act = A_CMP_RD;
        state_d   = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        priority if (status_i.weq && status_i.j_zero) begin
          state_d = S_MATCH;
        end else if (status_i.weq) begin
          cmd_o.act = A_J_DEC;
          state_d   = S_CMP_RD;
        end else begin
          cmd_o.act = A_SHIFT_RD;
          state_d   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.act = A_SHIFT_WR;
        state_d   = S_IDLE;
      end
      S_MATCH: begin
        // hold until the result register can take the beat
        if (!status_i.out_full) begin
          cmd_o.act = A_EMIT;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[rtl/core/bmbs_dp.sv]
// Datapath: pattern and text memories, shift tables, counters, result register.
module bmbs_dp import bmbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               cfg_we_i,
  input  logic [LEN_W-1:0]   cfg_wdata_i,
  input  logic [1:0]         operation_i,
  input  logic [4:0]         pattern_index_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        match_offset_o,
  output logic [31:0]        line_no_o
);

  logic [7:0]       pat_mem [PAT_MAX];
  logic [7:0]       win_mem [PAT_MAX];
  logic [LEN_W-1:0] bc_mem  [ALPHA];
  logic [LEN_W-1:0] gs_mem  [PAT_MAX];
  logic [ALPHA-1:0] bcv_q;

  logic             ready_q, out_valid_q;
  logic [LEN_W-1:0] len_q;
  logic [31:0]      pos_q, nce_q, nl_q, p_q;
  logic [31:0]      off_q, line_q;
  op_e              op_q;
  logic [4:0]       idx_q;
  logic [7:0]       byte_q;
  logic [LEN_W-1:0] i_q, k_q, j_q, lastpre_q, inside_q;
  logic [7:0]       pd_a_q, pd_b_q, wd_q;
  logic [LEN_W-1:0] bd_q, gd_q;
  logic             bvd_q;

  logic [LEN_W-1:0]  n, n_m1, bval, shift;
  logic [PAT_AW-1:0] ra_a, ra_b, wra;
  logic [31:0]       t_pos, start_pos, line_val;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? U32_TOP : s[31:0];
  endfunction

  assign n    = (len_q > LEN_W'(PAT_MAX)) ? LEN_W'(PAT_MAX) : len_q;
  assign n_m1 = n - LEN_W'(1);

  always_comb begin
    ra_a = '0;
    ra_b = '0;
    wra  = '0;
    unique case (cmd_i.act)
      A_BC_RD:  ra_a = i_q[PAT_AW-1:0];
      A_GS1_RD: begin
        ra_a = k_q[PAT_AW-1:0];
        ra_b = PAT_AW'(i_q + k_q + LEN_W'(1));
      end
      A_GS2_RD: begin
        ra_a = PAT_AW'(i_q - k_q);
        ra_b = PAT_AW'(n_m1 - k_q);
      end
      A_CMP_RD: begin
        ra_a = j_q[PAT_AW-1:0];
        wra  = p_q[PAT_AW-1:0] - PAT_AW'(n_m1 - j_q);
      end
      default: ;
    endcase
  end

  assign t_pos     = p_q - 32'(n_m1 - j_q);
  assign start_pos = p_q - 32'(n_m1);
  assign bval      = bvd_q ? bd_q : n;
  assign shift     = (bval > gd_q) ? bval : gd_q;
  assign line_val  = (nl_q == U32_TOP) ? U32_TOP : (nl_q - 32'(inside_q) + 32'd1);

  // memories: registered reads every cycle
  always_ff @(posedge clk_i) begin
    pd_a_q <= pat_mem[ra_a];
    pd_b_q <= pat_mem[ra_b];
    wd_q   <= win_mem[wra];
    bd_q   <= bc_mem[wd_q];
    bvd_q  <= bcv_q[wd_q];
    gd_q   <= gs_mem[j_q[PAT_AW-1:0]];
    if (cmd_i.act == A_PAT_WR) begin
      pat_mem[idx_q] <= byte_q;
    end
    if (cmd_i.act == A_STORE) begin
      win_mem[pos_q[PAT_AW-1:0]] <= byte_q;
    end
    if (cmd_i.act == A_BC_WR && i_q != n_m1) begin
      bc_mem[pd_a_q] <= n_m1 - i_q;
    end
    unique case (cmd_i.act)
      A_GS1_WRT: gs_mem[i_q[PAT_AW-1:0]] <= n;
      A_GS1_WRF: gs_mem[i_q[PAT_AW-1:0]] <= lastpre_q + n_m1 - i_q;
      A_GS2_WR:  if (pd_a_q != pd_b_q) begin
        gs_mem[PAT_AW'(n_m1 - k_q)] <= n_m1 - i_q + k_q;
      end
      default: ;
    endcase
  end

  // payload and loop counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_e'(operation_i);
      idx_q  <= pattern_index_i;
      byte_q <= data_byte_i;
    end
    unique case (cmd_i.act)
      A_INIT: begin
        i_q      <= '0;
        inside_q <= '0;
      end
      A_BC_WR: begin
        if (pd_a_q == NEWLINE) inside_q <= inside_q + LEN_W'(1);
        i_q <= i_q + LEN_W'(1);
      end
      A_GS1_INIT: begin
        lastpre_q <= n;
        i_q       <= n_m1;
        k_q       <= '0;
      end
      A_GS1_WRT: begin
        lastpre_q <= i_q + LEN_W'(1);
        i_q       <= i_q - LEN_W'(1);
        k_q       <= '0;
      end
      A_GS1_WRF: begin
        i_q <= i_q - LEN_W'(1);
        k_q <= '0;
      end
      A_K_INC: k_q <= k_q + LEN_W'(1);
      A_GS2_INIT: begin
        i_q <= '0;
        k_q <= '0;
      end
      A_GS2_WR: begin
        i_q <= i_q + LEN_W'(1);
        k_q <= '0;
      end
      A_STORE: begin
        p_q <= pos_q;
        j_q <= n_m1;
      end
      A_J_DEC: j_q <= j_q - LEN_W'(1);
      A_EMIT: begin
        off_q  <= start_pos;
        line_q <= line_val;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= 1'b0;
      len_q       <= '0;
      pos_q       <= '0;
      nce_q       <= '0;
      nl_q        <= '0;
      out_valid_q <= 1'b0;
      bcv_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q   <= cfg_wdata_i;
        ready_q <= 1'b0;
      end
      // drop the beat once taken, unless a new one loads in the same cycle
      if (out_valid_q && out_ready_i && cmd_i.act != A_EMIT) out_valid_q <= 1'b0;
      unique case (cmd_i.act)
        A_PAT_WR: ready_q <= 1'b0;
        A_EOT: begin
          pos_q   <= '0;
          nl_q    <= '0;
          ready_q <= 1'b0;
        end
        A_INIT: bcv_q <= '0;
        A_BC_WR: if (i_q != n_m1) bcv_q[pd_a_q] <= 1'b1;
        A_DONE: begin
          ready_q <= 1'b1;
          nce_q   <= (n == '0) ? pos_q : sat_add(pos_q, 32'(n_m1));
        end
        A_STORE: begin
          pos_q <= pos_q + 32'd1;
          if (byte_q == NEWLINE && nl_q != U32_TOP) nl_q <= nl_q + 32'd1;
        end
        A_SHIFT_WR: nce_q <= sat_add(t_pos, 32'(shift));
        A_EMIT: begin
          nce_q       <= sat_add(p_q, 32'(n));
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status_o.op           = op_q;
  assign status_o.pos_max      = (pos_q == U32_TOP);
  assign status_o.tables_ready = ready_q;
  assign status_o.n_zero       = (n == '0);
  assign status_o.n_one        = (n == LEN_W'(1));
  assign status_o.i_last       = (i_q == n_m1);
  assign status_o.i_zero       = (i_q == '0);
  assign status_o.i_last2      = (i_q == n - LEN_W'(2));
  assign status_o.k_done       = (k_q == n_m1 - i_q);
  assign status_o.k_lt_i       = (k_q < i_q);
  assign status_o.eq           = (pd_a_q == pd_b_q);
  assign status_o.weq          = (wd_q == pd_a_q);
  assign status_o.j_zero       = (j_q == '0);
  assign status_o.cmp_now      = (n != '0) && (pos_q == nce_q);
  assign status_o.out_full     = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign match_offset_o = off_q;
  assign line_no_o      = line_q;

endmodule

[rtl/core/boyer_moore_byte_search_top.sv]
// Boyer-Moore byte search over a streamed text: top level.
//
// Write pattern bytes, set pattern_length, then stream text bytes; each
// match reports its offset and line number through a result register, and
// the next input beat is taken while a result waits. One shared sequencer
// runs every step: a text byte that ends no alignment passes through accept,
// decode and store; one that ends an alignment then reads and checks each
// compared byte and ends with the shift update, or with the emit of a match
// (held while an earlier result still waits). The first text byte after a
// pattern change or end of text rebuilds the tables first: a bad-character
// pass and then the good-suffix passes (pattern length at most 32), all
// through the two read ports of the pattern memory. No clearing pass follows
// reset.
module boyer_moore_byte_search_top import bmbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  bmbs_in_if.sink          in_i,
  bmbs_out_if.source       out_o
);

  cmd_t    cmd;
  status_t status;

  bmbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bmbs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (in_i.operation),
    .pattern_index_i (in_i.pattern_index),
    .data_byte_i     (in_i.data_byte),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .match_offset_o  (out_o.match_offset),
    .line_no_o       (out_o.line_no)
  );

endmodule

[rtl/core/bmbs_checker.sv]
// Port-level assertions for the byte search top level, bound to it.
module bmbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] match_offset_i,
  input logic [31:0] line_no_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(match_offset_i) && $stable(line_no_i))
    else $error("result payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again before the beat was decoded");

  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised while the block was idle");

endmodule

bind boyer_moore_byte_search_top bmbs_checker u_bmbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .match_offset_i (out_o.match_offset),
  .line_no_i      (out_o.line_no)
);

[tb/sv/boyer_moore_byte_search_top_test.sv]
// Self-checking testbench for the Boyer-Moore byte search top level.
`timescale 1ns / 1ps

module boyer_moore_byte_search_top_test import bmbs_pkg::*; ();

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [31:0] offset;
    logic [31:0] line;
  } match_t;

  typedef struct {
    bit          is_cfg;
    op_e         op;
    logic [4:0]  idx;
    logic [7:0]  dat;
    bit          typed;
    logic [31:0] offset;
    logic [31:0] line;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;

  bmbs_in_if  in_bus ();
  bmbs_out_if out_bus ();

  boyer_moore_byte_search_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus.sink),
    .out_o       (out_bus.source)
  );

  // Search model state
  logic [LEN_W-1:0] model_len;
  logic [7:0]       model_pat [PAT_MAX];
  bit               pat_written [PAT_MAX];
  int               bad_shift [ALPHA];
  int               good_shift [PAT_MAX];
  bit               model_tables_ok;
  logic [7:0]       model_win [PAT_MAX];
  logic [31:0]      model_pos;
  logic [31:0]      model_cmp_end;
  logic [31:0]      model_nl;

  match_t pending_matches [$];
  int     mismatch_cnt;
  int     burst_left;
  int     gap_left;
  bit     no_gaps;
  int     idle_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] sat32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? U32_TOP : v[31:0];
  endfunction

  function automatic bit tail_is_prefix(int n, int pos);
    for (int k = 0; k < n - pos; k++)
      if (model_pat[k] != model_pat[pos + k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void build_shift_tables(int n);
    int lastpre;
    int s;
    for (int c = 0; c < ALPHA; c++) bad_shift[c] = n;
    for (int p = 0; p < n - 1; p++) bad_shift[model_pat[p]] = n - 1 - p;
    lastpre = n;
    for (int p = n - 1; p >= 0; p--) begin
      if (tail_is_prefix(n, p + 1)) lastpre = p + 1;
      good_shift[p] = lastpre + (n - 1 - p);
    end
    for (int p = 0; p < n - 1; p++) begin
      s = 0;
      while (s < p && model_pat[p - s] == model_pat[n - 1 - s]) s++;
      if (model_pat[p - s] != model_pat[n - 1 - s]) good_shift[n - 1 - s] = n - 1 - p + s;
    end
  endfunction

  function automatic void search_step(input op_e op, input logic [4:0] idx,
                                      input logic [7:0] b, output bit hit,
                                      output match_t m);
    int n;
    int j;
    int pat_nl;
    logic [31:0] p;
    logic [31:0] t;
    int s1;
    int s2;
    hit = 1'b0;
    m.offset = '0;
    m.line = '0;
    case (op)
      OP_PAT: begin
        model_pat[idx] = b;
        model_tables_ok = 1'b0;
        return;
      end
      OP_EOT: begin
        model_pos = '0;
        model_nl = '0;
        model_tables_ok = 1'b0;
        return;
      end
      OP_TEXT: ;
      default: return;
    endcase
    if (model_pos == U32_TOP) return;
    n = (model_len > PAT_MAX) ? PAT_MAX : model_len;
    p = model_pos;
    if (!model_tables_ok) begin
      build_shift_tables(n);
      model_cmp_end = (n > 0) ? sat32(longint'(p) + n - 1) : p;
      model_tables_ok = 1'b1;
    end
    model_win[p[4:0]] = b;
    if (b == NEWLINE && model_nl != U32_TOP) model_nl++;
    model_pos = p + 1;
    if (n == 0 || p != model_cmp_end) return;
    j = n - 1;
    while (j >= 0) begin
      t = p - (n - 1 - j);
      if (model_win[t[4:0]] != model_pat[j]) break;
      j--;
    end
    if (j < 0) begin
      hit = 1'b1;
      m.offset = p - (n - 1);
      model_cmp_end = sat32(longint'(p) + n);
      if (model_nl == U32_TOP) begin
        m.line = U32_TOP;
      end else begin
        pat_nl = 0;
        for (int k = 0; k < n; k++) if (model_pat[k] == NEWLINE) pat_nl++;
        m.line = (model_nl < pat_nl) ? U32_TOP : sat32(longint'(model_nl) - pat_nl + 1);
      end
    end else begin
      t = p - (n - 1 - j);
      s1 = bad_shift[model_win[t[4:0]]];
      s2 = good_shift[j];
      model_cmp_end = sat32(longint'(t) + ((s1 > s2) ? s1 : s2));
    end
  endfunction

  // Drive one input beat with burst/gap pacing, then update the model
  task automatic send_beat(op_e op, logic [4:0] idx, logic [7:0] dat,
                           bit typed, logic [31:0] t_off, logic [31:0] t_line);
    bit hit;
    match_t m;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = no_gaps ? 0 : $urandom_range(0, 6);
    end
    while (gap_left > 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      gap_left--;
    end
    @(negedge clk_i);
    in_bus.valid         <= 1'b1;
    in_bus.operation     <= op;
    in_bus.pattern_index <= idx;
    in_bus.data_byte     <= dat;
    do @(posedge clk_i); while (!in_bus.ready);
    burst_left--;
    if (op == OP_PAT) pat_written[idx] = 1'b1;
    search_step(op, idx, dat, hit, m);
    if (typed) begin
      m.offset = t_off;
      m.line = t_line;
      pending_matches.push_back(m);
    end else if (hit) begin
      pending_matches.push_back(m);
    end
  endtask

  // Hold until every result is in and the block is back to idle
  task automatic drain();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_matches.size() != 0 || !in_bus.ready) @(negedge clk_i);
  endtask

  task automatic write_len(logic [LEN_W-1:0] len);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model_len = len;
    model_tables_ok = 1'b0;
  endtask

  function automatic logic [7:0] pick_pat_byte();
    case ($urandom_range(0, 3))
      0: return 8'h61;
      1: return 8'h62;
      2: return NEWLINE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_matches.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: offset %0d line %0d",
                   out_bus.match_offset, out_bus.line_no);
      end else begin
        want = pending_matches.pop_front();
        if (out_bus.match_offset !== want.offset || out_bus.line_no !== want.line) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: expected offset %0d line %0d, got offset %0d line %0d",
                     want.offset, want.line, out_bus.match_offset, out_bus.line_no);
        end
      end
    end
  end

  // Receiver stalls in stretches of varying strength
  int ready_left;
  int ready_pct;
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_left = $urandom_range(20, 300);
      case ($urandom_range(0, 2))
        0: ready_pct = 100;
        1: ready_pct = 60;
        default: ready_pct = 25;
      endcase
    end
    ready_left--;
    out_bus.ready <= ($urandom_range(1, 100) <= ready_pct);
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{0, OP_TEXT, 5'd0,  8'h78, 0, 0, 0},   // empty pattern: counted, never reported
    '{0, OP_PAT,  5'd0,  8'h61, 0, 0, 0},
    '{0, OP_PAT,  5'd1,  8'h0A, 0, 0, 0},
    '{0, OP_NONE, 5'd31, 8'hFF, 0, 0, 0},
    '{1, OP_PAT,  5'd0,  8'd2,  0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h61, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h0A, 1, 1, 1},
    '{0, OP_TEXT, 5'd0,  8'h61, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h0A, 1, 3, 2},
    '{0, OP_EOT,  5'd0,  8'h00, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h61, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h0A, 1, 0, 1},
    '{0, OP_PAT,  5'd31, 8'hFF, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'hFF, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h61, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h0A, 0, 0, 0},
    '{0, OP_PAT,  5'd2,  8'h00, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h00, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h61, 0, 0, 0},
    '{0, OP_TEXT, 5'd0,  8'h0A, 0, 0, 0}
  };

  int phase_len [10] = '{1, 3, 2, 32, 5, 63, 0, 8, 4, 17};

  initial begin
    int n;
    int r;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_NONE;
    in_bus.pattern_index = '0;
    in_bus.data_byte = '0;
    burst_left = 0;
    gap_left = 0;
    no_gaps = 1'b0;
    model_len = '0;
    model_tables_ok = 1'b0;
    model_pos = '0;
    model_cmp_end = '0;
    model_nl = '0;
    foreach (model_pat[i]) begin
      model_pat[i] = '0;
      model_win[i] = '0;
      pat_written[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_len(directed[i].dat[LEN_W-1:0]);
      end else begin
        send_beat(directed[i].op, directed[i].idx, directed[i].dat,
                  directed[i].typed, directed[i].offset, directed[i].line);
      end
    end

    foreach (phase_len[ph]) begin
      drain();
      no_gaps = (ph % 3 == 1);
      n = (phase_len[ph] > PAT_MAX) ? PAT_MAX : phase_len[ph];
      for (int i = 0; i < n; i++)
        if (!pat_written[i] || $urandom_range(0, 1))
          send_beat(OP_PAT, 5'(i), pick_pat_byte(), 0, 0, 0);
      drain();
      write_len(LEN_W'(phase_len[ph]));
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_beat(OP_NONE, 5'($urandom), 8'($urandom), 0, 0, 0);
        end else if (r < 7) begin
          send_beat(OP_EOT, 5'($urandom), 8'($urandom), 0, 0, 0);
        end else if (r < 10) begin
          // pattern change mid-text; any index may be rewritten
          send_beat(OP_PAT, 5'($urandom), pick_pat_byte(), 0, 0, 0);
        end else if (r < 30 && n > 0) begin
          for (int i = 0; i < n; i++)
            send_beat(OP_TEXT, 5'($urandom), model_pat[i], 0, 0, 0);
          k += n / 4;
        end else if (r < 80 && n > 0) begin
          send_beat(OP_TEXT, 5'($urandom),
                    ($urandom_range(0, 4) == 0) ? NEWLINE : model_pat[$urandom_range(0, n - 1)],
                    0, 0, 0);
        end else begin
          send_beat(OP_TEXT, 5'($urandom), 8'($urandom), 0, 0, 0);
        end
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
